/* rtl/rpic_pkg.sv */
// Package for the rule prefix index and range cost core.
// Holds the transaction structs, the queue entry type and fixed field widths.
// No dependencies.
package rpic_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W = 6;
    localparam int PORT_W = 16;
    localparam int NODE_W = 33;
    localparam int CNT_W = 5;
    localparam int COST_W = 10;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [LEN_W-1:0]  src_len;
        logic [ADDR_W-1:0] dst_addr;
        logic [LEN_W-1:0]  dst_len;
        logic [PORT_W-1:0] sport_lo;
        logic [PORT_W-1:0] sport_hi;
        logic [PORT_W-1:0] dport_lo;
        logic [PORT_W-1:0] dport_hi;
    } in_t;

    typedef struct packed {
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
        logic [CNT_W-1:0]  sport_prefixes;
        logic [CNT_W-1:0]  dport_prefixes;
        logic [COST_W-1:0] expansion_cost;
    } out_t;

    typedef struct packed {
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
        logic [PORT_W-1:0] sport_lo;
        logic [PORT_W-1:0] sport_hi;
        logic [PORT_W-1:0] dport_lo;
        logic [PORT_W-1:0] dport_hi;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* rtl/rpic_front.sv */
// Front end: accepts rule transactions, works out both trie node indices and
// trims the port bounds, then pushes a job into the queue. Uses rpic_pkg.
module rpic_front
    import rpic_pkg::*;
#(
    parameter int ADDR_BITS = 32,
    parameter int PORT_BITS = 16
) (
    input  logic      s_valid,
    output logic      s_ready,
    input  in_t       s_data,
    input  q_status_t q_status,
    output logic      push,
    output job_t      push_data
);

    localparam logic [LEN_W-1:0] ADDR_LEN = LEN_W'(ADDR_BITS);

    function automatic logic [NODE_W-1:0] trie_node(input logic [ADDR_W-1:0] addr,
                                                   input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0]  l_sat;
        logic [LEN_W-1:0]  shamt;
        logic [NODE_W-1:0] a_ext;
        logic [NODE_W-1:0] base;
        l_sat = (len > ADDR_LEN) ? ADDR_LEN : len;
        shamt = ADDR_LEN - l_sat;
        a_ext = {{(NODE_W-ADDR_BITS){1'b0}}, addr[ADDR_BITS-1:0]};
        base  = (NODE_W'(1) << l_sat) - NODE_W'(1);
        if (l_sat == '0) begin
            return '0;
        end
        return base + (a_ext >> shamt);
    endfunction

    function automatic logic [PORT_W-1:0] trim_port(input logic [PORT_W-1:0] p);
        return {{(PORT_W-PORT_BITS){1'b0}}, p[PORT_BITS-1:0]};
    endfunction

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_data.src_node = trie_node(s_data.src_addr, s_data.src_len);
        push_data.dst_node = trie_node(s_data.dst_addr, s_data.dst_len);
        push_data.sport_lo = trim_port(s_data.sport_lo);
        push_data.sport_hi = trim_port(s_data.sport_hi);
        push_data.dport_lo = trim_port(s_data.dport_lo);
        push_data.dport_hi = trim_port(s_data.dport_hi);
    end

endmodule

/* rtl/rpic_queue.sv */
// Short job queue between the front end and the range counter.
// Two entries of job_t from rpic_pkg, first in first out.
module rpic_queue
    import rpic_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  job_t      push_data,
    input  logic      pop,
    output job_t      pop_data,
    output q_status_t q_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] fill_reg, fill_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign q_status.full  = (fill_reg == CNT_QW'(QUEUE_DEPTH));
    assign q_status.empty = (fill_reg == '0);
    assign pop_data       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + CNT_QW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/rpic_back.sv */
// Back end: takes jobs from the queue, splits both port ranges into aligned
// blocks one block per cycle, and holds the result transaction. Uses rpic_pkg.
module rpic_back
    import rpic_pkg::*;
#(
    parameter int PORT_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  q_status_t q_status,
    input  job_t      pop_data,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_t      m_data
);

    localparam int PW1 = PORT_BITS + 1;
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [PW1-1:0]   now_s_reg, now_s_next, now_d_reg, now_d_next;
    logic [PW1-1:0]   hi_s_reg, hi_d_reg;
    logic [CNT_W-1:0] cnt_s_reg, cnt_s_next, cnt_d_reg, cnt_d_next;
    logic [NODE_W-1:0] src_node_reg, dst_node_reg;
    logic             m_valid_reg, m_valid_next;
    out_t             out_reg;
    logic             act_s, act_d, finish, load;
    logic [PW1-1:0]   rem_s, rem_d;

    function automatic logic [PW1-1:0] block_size(input logic [PW1-1:0] now,
                                                 input logic [PW1-1:0] rem);
        logic [PW1-1:0] size;
        logic [PW1-1:0] low_mask;
        size = '0;
        for (int k = 0; k <= PORT_BITS; k++) begin
            low_mask = (PW1'(1) << k) - PW1'(1);
            if (((rem >> k) != '0) && ((now & low_mask) == '0)) begin
                size = PW1'(1) << k;
            end
        end
        return size;
    endfunction

    assign act_s  = (now_s_reg <= hi_s_reg);
    assign act_d  = (now_d_reg <= hi_d_reg);
    assign rem_s  = hi_s_reg - now_s_reg + PW1'(1);
    assign rem_d  = hi_d_reg - now_d_reg + PW1'(1);
    assign load   = (state_reg == ST_IDLE) && !q_status.empty;
    assign pop    = load;
    assign finish = (state_reg == ST_RUN) && !act_s && !act_d
                    && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        now_s_next   = now_s_reg;
        now_d_next   = now_d_reg;
        cnt_s_next   = cnt_s_reg;
        cnt_d_next   = cnt_d_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (load) begin
                    state_next = ST_RUN;
                    now_s_next = {1'b0, pop_data.sport_lo[PORT_BITS-1:0]};
                    now_d_next = {1'b0, pop_data.dport_lo[PORT_BITS-1:0]};
                    cnt_s_next = '0;
                    cnt_d_next = '0;
                end
            end
            ST_RUN: begin
                if (act_s) begin
                    now_s_next = now_s_reg + block_size(now_s_reg, rem_s);
                    cnt_s_next = cnt_s_reg + CNT_W'(1);
                end
                if (act_d) begin
                    now_d_next = now_d_reg + block_size(now_d_reg, rem_d);
                    cnt_d_next = cnt_d_reg + CNT_W'(1);
                end
                if (finish) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_s_reg <= now_s_next;
        now_d_reg <= now_d_next;
        cnt_s_reg <= cnt_s_next;
        cnt_d_reg <= cnt_d_next;
        if (load) begin
            hi_s_reg     <= {1'b0, pop_data.sport_hi[PORT_BITS-1:0]};
            hi_d_reg     <= {1'b0, pop_data.dport_hi[PORT_BITS-1:0]};
            src_node_reg <= pop_data.src_node;
            dst_node_reg <= pop_data.dst_node;
        end
        if (finish) begin
            out_reg.src_node       <= src_node_reg;
            out_reg.dst_node       <= dst_node_reg;
            out_reg.sport_prefixes <= cnt_s_reg;
            out_reg.dport_prefixes <= cnt_d_reg;
            out_reg.expansion_cost <= COST_W'({{(COST_W-CNT_W){1'b0}}, cnt_s_reg}
                                              * {{(COST_W-CNT_W){1'b0}}, cnt_d_reg});
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_lane_s_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && act_s |=> now_s_reg > $past(now_s_reg))
        else $error("Source port cursor failed to advance.");

    a_lane_d_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && act_d |=> now_d_reg > $past(now_d_reg))
        else $error("Destination port cursor failed to advance.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (cnt_s_reg <= CNT_W'(2 * PORT_BITS - 2))
                                  && (cnt_d_reg <= CNT_W'(2 * PORT_BITS - 2)))
        else $error("Block count exceeds the bound for the port width.");

    a_cost_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> out_reg.expansion_cost == COST_W'(
            {{(COST_W-CNT_W){1'b0}}, out_reg.sport_prefixes}
            * {{(COST_W-CNT_W){1'b0}}, out_reg.dport_prefixes}))
        else $error("Expansion cost does not match the two block counts.");
`endif

endmodule

/* rtl/rule_prefix_index_and_range_cost_core.sv */
// Each rule transaction gives the heap trie node of its source and destination prefixes
// and the number of aligned blocks covering each port range, with their product as the
// expansion cost. The node indices are formed as the rule enters; the two port ranges
// are then split one block per cycle, side by side, so a rule occupies the range counter
// until both ranges are split and any earlier result has been taken. A two-entry queue
// sits between entry and the counter, and the result register lets the next rule start
// while a result waits to be taken.
module rule_prefix_index_and_range_cost_core
    import rpic_pkg::*;
#(
    parameter int ADDR_BITS = 32,
    parameter int PORT_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    q_status_t q_status;
    logic      push, pop;
    job_t      push_data, pop_data;

    rpic_front #(
        .ADDR_BITS(ADDR_BITS),
        .PORT_BITS(PORT_BITS)
    ) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .push     (push),
        .push_data(push_data)
    );

    rpic_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .q_status (q_status)
    );

    rpic_back #(
        .PORT_BITS(PORT_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_status(q_status),
        .pop_data(pop_data),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
